[rtl/pitl_pkg.sv]
// shared types and codes of the page interval table lookup core
// no dependencies
package pitl_pkg;

    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 72;

    typedef struct packed {
        logic        mode;
        logic [31:0] start_page;
        logic [31:0] page_count;
        logic [31:0] owner_table;
        logic        rel_flag;
        logic [31:0] query_page;
    } item_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] found_table;
        logic        found_rel;
        logic [1:0]  add_status;
        logic [31:0] largest_table;
    } result_t;

    typedef struct packed {
        logic        rel;
        logic [31:0] owner;
        logic [32:0] end_page;
        logic [31:0] start_page;
    } entry_t;

endpackage

[rtl/pitl_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module pitl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pitl_ctrl.sv]
// sequencer of the lookup core: binary search, insert shifting, shared comparator
// depends on pitl_pkg
module pitl_ctrl #(
    parameter int MAX_INTERVALS = 64,
    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1,
    localparam int CW = $clog2(MAX_INTERVALS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  pitl_pkg::item_t    req_item,
    output logic               res_valid,
    input  logic               res_ready,
    output pitl_pkg::result_t  res,
    output logic [AW-1:0]      rd_addr,
    input  pitl_pkg::entry_t   rd_data,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output pitl_pkg::entry_t   wr_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PROBE  = 5'b00010,
        ST_LCHECK = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_INSERT = 5'b10000
    } state_t;

    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_INTERVALS);
    localparam logic [CW-1:0] ONE       = CW'(1);

    state_t            state_reg, state_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [31:0]       max_owner_reg, max_owner_next;
    pitl_pkg::item_t   item_reg, item_next;
    pitl_pkg::result_t res_reg, res_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     mid_reg, mid_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     idx_reg, idx_next;

    logic [32:0]       cmp_a, cmp_b;
    logic              cmp_lt;
    logic              search_fin;
    logic [CW-1:0]     fin_pos;
    logic [CW-1:0]     addr_wide;
    logic [31:0]       key;

    // shared comparator
    assign cmp_lt = cmp_a < cmp_b;
    assign key = (item_reg.mode == pitl_pkg::MODE_LOOKUP) ? item_reg.query_page
                                                          : item_reg.start_page;

    always_comb
    begin
        state_next     = state_reg;
        done_next      = done_reg;
        count_next     = count_reg;
        max_owner_next = max_owner_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        cmp_a          = {1'b0, key};
        cmp_b          = {1'b0, rd_data.start_page};
        search_fin     = 1'b0;
        fin_pos        = lo_reg;
        addr_wide      = mid_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[AW-1:0];
        wr_data        = rd_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (done_reg)
                begin
                    if (res_ready)
                    begin
                        done_next = 1'b0;
                    end
                end
                else if (req_valid)
                begin
                    item_next = req_item;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    res_next  = '{hit: 1'b0, found_table: 32'd0, found_rel: 1'b0,
                                  add_status: pitl_pkg::STATUS_OK,
                                  largest_table: max_owner_reg};
                    if (req_item.mode == pitl_pkg::MODE_ADD && req_item.page_count == 32'd0)
                    begin
                        res_next.add_status = pitl_pkg::STATUS_EMPTY;
                        done_next = 1'b1;
                    end
                    else if (req_item.mode == pitl_pkg::MODE_ADD && count_reg == MAX_COUNT)
                    begin
                        res_next.add_status = pitl_pkg::STATUS_FULL;
                        done_next = 1'b1;
                    end
                    else if (count_reg != '0)
                    begin
                        mid_next   = count_reg >> 1;
                        addr_wide  = mid_next;
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        search_fin = 1'b1;
                        fin_pos    = '0;
                    end
                end
            end
            ST_PROBE:
            begin
                if (cmp_lt)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + ONE;
                end
                if (lo_next < hi_next)
                begin
                    mid_next  = lo_next + ((hi_next - lo_next) >> 1);
                    addr_wide = mid_next;
                end
                else
                begin
                    search_fin = 1'b1;
                    fin_pos    = lo_next;
                end
            end
            ST_LCHECK:
            begin
                cmp_a = {1'b0, item_reg.query_page};
                cmp_b = rd_data.end_page;
                if (cmp_lt)
                begin
                    res_next.hit         = 1'b1;
                    res_next.found_table = rd_data.owner;
                    res_next.found_rel   = rd_data.rel;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[AW-1:0];
                wr_data  = rd_data;
                idx_next = idx_reg - ONE;
                if (idx_next > pos_reg)
                begin
                    addr_wide = idx_next - ONE;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[AW-1:0];
                wr_data = '{rel: item_reg.rel_flag, owner: item_reg.owner_table,
                            end_page: {1'b0, item_reg.start_page}
                                      + {1'b0, item_reg.page_count},
                            start_page: item_reg.start_page};
                count_next = count_reg + ONE;
                cmp_a = {1'b0, max_owner_reg};
                cmp_b = {1'b0, item_reg.owner_table};
                if (cmp_lt)
                begin
                    max_owner_next = item_reg.owner_table;
                end
                res_next.largest_table = max_owner_next;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // end of the search: pick the follow-up step from the found position
        if (search_fin)
        begin
            pos_next = fin_pos;
            if (item_next.mode == pitl_pkg::MODE_LOOKUP)
            begin
                if (fin_pos == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_wide  = fin_pos - ONE;
                    state_next = ST_LCHECK;
                end
            end
            else
            begin
                idx_next = count_reg;
                if (count_reg > fin_pos)
                begin
                    addr_wide  = count_reg - ONE;
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
        end
    end

    assign rd_addr   = addr_wide[AW-1:0];
    assign req_ready = (state_reg == ST_IDLE) && !done_reg;
    assign res_valid = done_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            count_reg     <= '0;
            max_owner_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            count_reg     <= count_next;
            max_owner_reg <= max_owner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
    end

endmodule

[rtl/page_interval_table_lookup_core.sv]
// Sorted page interval table with add and lookup requests. One request is worked at a
// time. A lookup does a binary search with one read of the single interval ram per
// binary-search level, then one read to check the end of the interval found, and the
// result then passes into the output register; the end check is skipped when no
// interval starts at or below the page. An add does the same search, moves each stored
// interval above the found position up by one entry, writes the new interval and passes
// the result into the output register. An empty or full-table add finishes without
// touching the ram. The next request is taken as soon as the result sits in the output
// register. The ram holds MAX_INTERVALS entries and needs no clearing pass after reset.
//
// top level; depends on pitl_pkg, pitl_ram, pitl_ctrl
module page_interval_table_lookup_core #(
    parameter int MAX_INTERVALS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_page[31:0], page_count[63:32], owner_table[95:64], rel_flag[96],
    // query_page[128:97], zero pad
    input  logic [pitl_pkg::S_DATA_W-1:0] s_tdata,
    // mode[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit[0], found_table[32:1], found_rel[33], add_status[35:34],
    // largest_table[67:36], zero pad
    output logic [pitl_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

    pitl_pkg::item_t   req_item;
    pitl_pkg::result_t ctrl_res;
    pitl_pkg::result_t out_reg;
    pitl_pkg::entry_t  rd_data, wr_data;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic              wr_en;
    logic              res_valid, res_ready, res_take;
    logic              m_tvalid_reg, m_tvalid_next;

    assign req_item = '{mode: s_tuser, start_page: s_tdata[31:0],
                        page_count: s_tdata[63:32], owner_table: s_tdata[95:64],
                        rel_flag: s_tdata[96], query_page: s_tdata[128:97]};

    pitl_ctrl #(
        .MAX_INTERVALS(MAX_INTERVALS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(s_tvalid),
        .req_ready(s_tready),
        .req_item (req_item),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (ctrl_res),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    pitl_ram #(
        .WIDTH($bits(pitl_pkg::entry_t)),
        .DEPTH(MAX_INTERVALS)
    ) u_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    // output register
    assign res_ready     = !m_tvalid_reg || m_tready;
    assign res_take      = res_valid && res_ready;
    assign m_tvalid_next = res_take || (m_tvalid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= ctrl_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_reg.largest_table, out_reg.add_status,
                       out_reg.found_rel, out_reg.found_table, out_reg.hit};

`ifndef ASSERT_OFF
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while a request is in work");

    a_add_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[35:34] != pitl_pkg::STATUS_OK) |-> !m_tdata[0])
        else $error("hit reported on an add result");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[32:1] == 32'd0) && !m_tdata[33])
        else $error("miss result carries a table id or flag");
`endif

endmodule

[tb/sv/page_interval_table_lookup_core_tb.sv]
`timescale 1ns / 1ps
// testbench for page_interval_table_lookup_core: directed and random add and lookup
// requests, checked against a sorted interval table kept inside the bench
// depends on pitl_pkg and the core rtl
module page_interval_table_lookup_core_tb;

    localparam int TABLE_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 1150;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int S_W          = pitl_pkg::S_DATA_W;
    localparam int M_W          = pitl_pkg::M_DATA_W;
    localparam logic ADD        = pitl_pkg::MODE_ADD;
    localparam logic LOOKUP     = pitl_pkg::MODE_LOOKUP;

    logic           clk      = 1'b0;
    logic           rst_n    = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           s_tuser  = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    page_interval_table_lookup_core #(
        .MAX_INTERVALS(TABLE_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sorted interval table as the core should hold it
    logic [31:0] tbl_start [TABLE_DEPTH];
    logic [32:0] tbl_end   [TABLE_DEPTH];
    logic [31:0] tbl_owner [TABLE_DEPTH];
    logic        tbl_rel   [TABLE_DEPTH];
    int          tbl_count     = 0;
    logic [31:0] tbl_max_owner = '0;

    pitl_pkg::item_t   pending_requests [$];
    pitl_pkg::result_t expected_results [$];
    pitl_pkg::item_t   request_on_bus;

    // intervals known to the generator, for aiming lookups and add start pages
    logic [31:0] gen_start [$];
    logic [32:0] gen_end   [$];

    int total_items    = 0;
    int accepted_total = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_taken     = 1'b0;
    int add_total      = 0;
    int lookup_total   = 0;
    int hit_total      = 0;
    int empty_total    = 0;
    int full_total     = 0;

    function automatic int first_start_above(logic [31:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tbl_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (key < tbl_start[mid])
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic pitl_pkg::result_t apply_request(pitl_pkg::item_t req);
        pitl_pkg::result_t res;
        int                pos;
        int                i;
        res = '0;
        if (req.mode == ADD)
        begin
            if (req.page_count == 32'd0)
                res.add_status = pitl_pkg::STATUS_EMPTY;
            else if (tbl_count >= TABLE_DEPTH)
                res.add_status = pitl_pkg::STATUS_FULL;
            else
            begin
                pos = first_start_above(req.start_page);
                for (i = tbl_count; i > pos; i--)
                begin
                    tbl_start[i] = tbl_start[i-1];
                    tbl_end[i]   = tbl_end[i-1];
                    tbl_owner[i] = tbl_owner[i-1];
                    tbl_rel[i]   = tbl_rel[i-1];
                end
                tbl_start[pos] = req.start_page;
                tbl_end[pos]   = {1'b0, req.start_page} + {1'b0, req.page_count};
                tbl_owner[pos] = req.owner_table;
                tbl_rel[pos]   = req.rel_flag;
                tbl_count++;
                if (req.owner_table > tbl_max_owner)
                    tbl_max_owner = req.owner_table;
                res.add_status = pitl_pkg::STATUS_OK;
            end
        end
        else
        begin
            pos = first_start_above(req.query_page);
            if (pos > 0 && {1'b0, req.query_page} < tbl_end[pos-1])
            begin
                res.hit         = 1'b1;
                res.found_table = tbl_owner[pos-1];
                res.found_rel   = tbl_rel[pos-1];
            end
        end
        res.largest_table = tbl_max_owner;
        return res;
    endfunction

    function automatic int idle_pct(bit receiver_side);
        int phase;
        phase = (total_items == 0) ? 0 : accepted_total * 3 / total_items;
        if (phase == 0)
            return receiver_side ? 47 : 27;
        if (phase == 1)
            return receiver_side ? 27 : 47;
        return 0;
    endfunction

    task automatic push_request(logic mode, logic [31:0] start, logic [31:0] count,
                                logic [31:0] owner, logic rel, logic [31:0] query);
        pitl_pkg::item_t req;
        req.mode        = mode;
        req.start_page  = start;
        req.page_count  = count;
        req.owner_table = owner;
        req.rel_flag    = rel;
        req.query_page  = query;
        pending_requests = {pending_requests, req};
        if (mode == ADD && count != 32'd0 && gen_start.size() < TABLE_DEPTH)
        begin
            gen_start = {gen_start, start};
            gen_end   = {gen_end, {1'b0, start} + {1'b0, count}};
        end
    endtask

    function automatic logic [31:0] rand_start();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)
            return $urandom_range(0, 4000);
        if (sel < 50 && gen_start.size() != 0)
            return gen_start[$urandom_range(gen_start.size() - 1)];
        if (sel < 60)
            return 32'hFFFF_FFFF - $urandom_range(0, 200);
        return $urandom();
    endfunction

    function automatic logic [31:0] rand_count();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return $urandom_range(1, 300);
        if (sel < 62)
            return $urandom() | 32'd1;
        if (sel < 70)
            return 32'hFFFF_FFFF;
        if (sel < 78)
            return 32'd1;
        return $urandom_range(1, 100000);
    endfunction

    function automatic logic [31:0] rand_owner();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return 32'hFFFF_FFFF;
        if (sel < 30)
            return $urandom_range(0, 15);
        return $urandom();
    endfunction

    function automatic logic [31:0] rand_query();
        int          idx;
        logic [32:0] lo33;
        logic [32:0] hi33;
        logic [32:0] pick;
        if (gen_start.size() != 0 && $urandom_range(99) < 80)
        begin
            idx  = $urandom_range(gen_start.size() - 1);
            lo33 = {1'b0, gen_start[idx]};
            hi33 = gen_end[idx];
            case ($urandom_range(5))
                0:       pick = lo33 - 33'd1;
                1:       pick = lo33;
                2:       pick = lo33 + ({1'b0, $urandom()} % (hi33 - lo33));
                3:       pick = hi33 - 33'd1;
                4:       pick = hi33;
                default: pick = hi33 + 33'd1;
            endcase
            if (pick > 33'h0_FFFF_FFFF)
                pick = 33'h0_FFFF_FFFF;
            return pick[31:0];
        end
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
            error_count++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        pitl_pkg::result_t predicted;
        pitl_pkg::item_t   fresh;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predicted = apply_request(request_on_bus);
                expected_results = {expected_results, predicted};
                accepted_total <= accepted_total + 1;
                if (request_on_bus.mode == LOOKUP)
                begin
                    lookup_total++;
                    if (predicted.hit)
                        hit_total++;
                end
                else
                begin
                    add_total++;
                    if (predicted.add_status == pitl_pkg::STATUS_EMPTY)
                        empty_total++;
                    if (predicted.add_status == pitl_pkg::STATUS_FULL)
                        full_total++;
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct(1'b0))
                begin
                    fresh          = pending_requests.pop_front();
                    request_on_bus = fresh;
                    s_tvalid <= 1'b1;
                    s_tuser  <= fresh.mode;
                    s_tdata  <= {{(S_W-129){1'b0}}, fresh.query_page, fresh.rel_flag,
                                 fresh.owner_table, fresh.page_count, fresh.start_page};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off to back up the core
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (!hold_taken && results_seen >= HOLD_AFTER)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : check_results
        pitl_pkg::result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: m_tdata 0x%0h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(m_tdata[0]));
                    check_field("found_table", want.found_table, m_tdata[32:1]);
                    check_field("found_rel", 32'(want.found_rel), 32'(m_tdata[33]));
                    check_field("add_status", 32'(want.add_status), 32'(m_tdata[35:34]));
                    check_field("largest_table", want.largest_table, m_tdata[67:36]);
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d of %0d requests taken, %0d results owed",
                 cycle_count, accepted_total, total_items, expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        int sel;
        // empty table, ignored interval, simple hit and both borders
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
        push_request(ADD, 32'd5, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd0);
        push_request(ADD, 32'd100, 32'd10, 32'd7, 1'b1, 32'd0);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'd99);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'd100);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'd109);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'd110);
        // equal start, newest wins
        push_request(ADD, 32'd100, 32'd50, 32'd9, 1'b0, 32'd0);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'd120);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'd105);
        // overlap hidden behind a later start
        push_request(ADD, 32'd200, 32'd5, 32'd3, 1'b1, 32'd0);
        push_request(ADD, 32'd50, 32'd1000, 32'hFFFF_FFFF, 1'b1, 32'd0);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'd300);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'd60);
        // end past 32 bits
        push_request(ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
        push_request(ADD, 32'd0, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'd0);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0);
        push_request(ADD, 32'd0, 32'd1, 32'd2, 1'b1, 32'd0);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0);
        push_request(LOOKUP, 32'd0, 32'd0, 32'd0, 1'b0, 32'd1);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 4)
                push_request(ADD, $urandom(), 32'd0, $urandom(), 1'($urandom_range(1)),
                             $urandom());
            else if (sel < 16)
                push_request(ADD, rand_start(), rand_count(), rand_owner(),
                             1'($urandom_range(1)), $urandom());
            else
                push_request(LOOKUP, $urandom(), $urandom(), $urandom(),
                             1'($urandom_range(1)), rand_query());
        end
        total_items = pending_requests.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_total < total_items || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            error_count++;
        end

        $display("ran %0d requests: %0d adds (%0d empty, %0d on a full table), %0d lookups",
                 accepted_total, add_total, empty_total, full_total, lookup_total);
        $display("%0d lookups hit, table ended with %0d intervals, %0d cycles",
                 hit_total, tbl_count, cycle_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
